// File: rtl/arp_rc_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder and cache package
// Shared widths, protocol constants, command and result types.
// ----------------------------------------------------------------------------
package arp_rc_pkg;

    localparam int CACHE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;

    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'd1;
    localparam logic [15:0] OP_REPLY       = 16'd2;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    localparam int CQ_DEPTH = 2;
    localparam int RQ_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_REQUEST = 2'd2
    } frame_kind_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_ANSWER = 2'd1,
        CMD_LEARN  = 2'd2,
        CMD_LOOKUP = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cmd_t;

    typedef struct packed {
        frame_kind_t      kind;
        logic [MAC_W-1:0] dest_mac;
        logic [MAC_W-1:0] target_mac;
        logic [IP_W-1:0]  target_ip;
        logic             learned;
        logic             hit;
        logic [MAC_W-1:0] lookup_mac;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/arp_rc_front.sv
// ----------------------------------------------------------------------------
// ARP front end
// Holds the station address, checks received messages and turns each
// accepted item into a cache command.
// ----------------------------------------------------------------------------
module arp_rc_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [arp_rc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arp_rc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                push,
    input  logic                                action,
    input  logic                                long_enough,
    input  logic [15:0]                         hw_type,
    input  logic [15:0]                         proto_type,
    input  logic [7:0]                          hw_len,
    input  logic [7:0]                          proto_len,
    input  logic [15:0]                         opcode,
    input  logic [arp_rc_pkg::MAC_W-1:0]        sender_mac,
    input  logic [arp_rc_pkg::IP_W-1:0]         sender_ip,
    input  logic [arp_rc_pkg::IP_W-1:0]         target_ip,
    input  logic [arp_rc_pkg::IP_W-1:0]         query_ip,
    input  arp_rc_pkg::q_status_t               cq_status,
    output logic                                cmd_push,
    output arp_rc_pkg::cmd_t                    cmd
);

    logic [arp_rc_pkg::IP_W-1:0] own_ip_reg;
    logic [arp_rc_pkg::IP_W-1:0] own_ip_next;
    logic                        msg_ok;

    always_comb
    begin
        own_ip_next = own_ip_reg;
        if (cfg_we && (cfg_index == arp_rc_pkg::CFG_OWN_IP))
        begin
            own_ip_next = cfg_wdata[arp_rc_pkg::IP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else
        begin
            own_ip_reg <= own_ip_next;
        end
    end

    assign msg_ok = long_enough
                 && (hw_type == arp_rc_pkg::HW_TYPE_ETH)
                 && (proto_type == arp_rc_pkg::PROTO_IPV4)
                 && (hw_len == arp_rc_pkg::HW_LEN_ETH)
                 && (proto_len == arp_rc_pkg::PROTO_LEN_IPV4)
                 && (target_ip == own_ip_reg);

    always_comb
    begin
        cmd.op  = arp_rc_pkg::CMD_NONE;
        cmd.ip  = sender_ip;
        cmd.mac = sender_mac;
        if (action)
        begin
            cmd.op = arp_rc_pkg::CMD_LOOKUP;
            cmd.ip = query_ip;
        end
        else if (msg_ok && (opcode == arp_rc_pkg::OP_REQUEST))
        begin
            cmd.op = arp_rc_pkg::CMD_ANSWER;
        end
        else if (msg_ok && (opcode == arp_rc_pkg::OP_REPLY))
        begin
            cmd.op = arp_rc_pkg::CMD_LEARN;
        end
    end

    assign cmd_push = push && !cq_status.full;

endmodule

// File: rtl/arp_rc_cmdq.sv
// ----------------------------------------------------------------------------
// ARP command queue
// Short queue of classified commands between the front end and the cache.
// ----------------------------------------------------------------------------
module arp_rc_cmdq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  arp_rc_pkg::cmd_t      wr_data,
    input  logic                  rd_en,
    output arp_rc_pkg::cmd_t      rd_data,
    output arp_rc_pkg::q_status_t status
);

    localparam int PTR_W = $clog2(arp_rc_pkg::CQ_DEPTH);
    localparam int CNT_W = $clog2(arp_rc_pkg::CQ_DEPTH + 1);

    arp_rc_pkg::cmd_t mem [arp_rc_pkg::CQ_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (cnt_reg == CNT_W'(arp_rc_pkg::CQ_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(arp_rc_pkg::CQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(arp_rc_pkg::CQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/arp_rc_back.sv
// ----------------------------------------------------------------------------
// ARP cache back end
// Searches and updates the address cache, builds each result and holds
// finished results in an output queue.
// ----------------------------------------------------------------------------
module arp_rc_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  arp_rc_pkg::cmd_t      cmd,
    input  arp_rc_pkg::q_status_t cq_status,
    output logic                  cmd_pop,
    input  logic                  pop,
    output logic                  empty,
    output arp_rc_pkg::res_t      res
);

    localparam int SW    = arp_rc_pkg::SLOT_W;
    localparam int PTR_W = $clog2(arp_rc_pkg::RQ_DEPTH);
    localparam int CNT_W = $clog2(arp_rc_pkg::RQ_DEPTH + 1);

    logic [arp_rc_pkg::CACHE_SLOTS-1:0] valid_reg;
    logic [arp_rc_pkg::CACHE_SLOTS-1:0] valid_next;
    logic [arp_rc_pkg::IP_W-1:0]        slot_ip  [arp_rc_pkg::CACHE_SLOTS];
    logic [arp_rc_pkg::MAC_W-1:0]       slot_mac [arp_rc_pkg::CACHE_SLOTS];
    logic [SW-1:0]                      refill_reg;
    logic [SW-1:0]                      refill_next;

    logic          hit_any;
    logic [SW-1:0] hit_idx;
    logic          free_any;
    logic [SW-1:0] free_idx;
    logic          take;
    logic          slot_we;
    logic [SW-1:0] slot_widx;

    arp_rc_pkg::res_t res_new;
    arp_rc_pkg::res_t rq_mem [arp_rc_pkg::RQ_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rq_full;
    logic             do_rd;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = arp_rc_pkg::CACHE_SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (slot_ip[i] == cmd.ip))
            begin
                hit_any = 1'b1;
                hit_idx = SW'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign rq_full   = (cnt_reg == CNT_W'(arp_rc_pkg::RQ_DEPTH));
    assign take      = !cq_status.empty && !rq_full;
    assign cmd_pop   = take;
    assign slot_we   = take && (cmd.op == arp_rc_pkg::CMD_LEARN) && !hit_any;
    assign slot_widx = free_any ? free_idx : refill_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        refill_next = refill_reg;
        if (slot_we)
        begin
            valid_next[slot_widx] = 1'b1;
            if (!free_any)
            begin
                refill_next = (refill_reg == SW'(arp_rc_pkg::CACHE_SLOTS - 1)) ?
                              '0 : refill_reg + SW'(1);
            end
        end
    end

    always_comb
    begin
        res_new = '0;
        unique case (cmd.op)
            arp_rc_pkg::CMD_ANSWER:
            begin
                res_new.kind       = arp_rc_pkg::KIND_REPLY;
                res_new.dest_mac   = cmd.mac;
                res_new.target_mac = cmd.mac;
                res_new.target_ip  = cmd.ip;
            end
            arp_rc_pkg::CMD_LEARN:
            begin
                res_new.learned = !hit_any;
            end
            arp_rc_pkg::CMD_LOOKUP:
            begin
                if (hit_any)
                begin
                    res_new.hit        = 1'b1;
                    res_new.lookup_mac = slot_mac[hit_idx];
                end
                else
                begin
                    res_new.kind      = arp_rc_pkg::KIND_REQUEST;
                    res_new.dest_mac  = arp_rc_pkg::BCAST_MAC;
                    res_new.target_ip = cmd.ip;
                end
            end
            default:
            begin
                res_new = '0;
            end
        endcase
    end

    assign empty = (cnt_reg == '0);
    assign do_rd = pop && !empty;
    assign res   = rq_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (take)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(arp_rc_pkg::RQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(arp_rc_pkg::RQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (take && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            refill_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            refill_reg <= refill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_ip[slot_widx]  <= cmd.ip;
            slot_mac[slot_widx] <= cmd.mac;
        end
        if (take)
        begin
            rq_mem[wr_ptr_reg] <= res_new;
        end
    end

endmodule

// File: rtl/arp_responder_and_cache.sv
// Path: an item is written into the command queue, taken by the cache stage
// once the result queue has room, and its result is then held there for pop.
// Throughput: one item per cycle unless a queue is full, set by the parallel
// compare over all cache slots and the one-command-per-cycle back end.
// Reset: cache empty, refill pointer and station IP zero, both queues empty.
// ----------------------------------------------------------------------------
// ARP responder and address cache
// Answers ARP requests for the station IP, learns replies into a
// sixteen-slot cache and resolves lookups, requesting on a miss.
// ----------------------------------------------------------------------------
module arp_responder_and_cache
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [arp_rc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arp_rc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic                                action,
    input  logic                                long_enough,
    input  logic [15:0]                         hw_type,
    input  logic [15:0]                         proto_type,
    input  logic [7:0]                          hw_len,
    input  logic [7:0]                          proto_len,
    input  logic [15:0]                         opcode,
    input  logic [arp_rc_pkg::MAC_W-1:0]        sender_mac,
    input  logic [arp_rc_pkg::IP_W-1:0]         sender_ip,
    input  logic [arp_rc_pkg::IP_W-1:0]         target_ip,
    input  logic [arp_rc_pkg::IP_W-1:0]         query_ip,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          frame_kind,
    output logic [arp_rc_pkg::MAC_W-1:0]        frame_dest_mac,
    output logic [arp_rc_pkg::MAC_W-1:0]        frame_target_mac,
    output logic [arp_rc_pkg::IP_W-1:0]         frame_target_ip,
    output logic                                learned,
    output logic                                lookup_hit,
    output logic [arp_rc_pkg::MAC_W-1:0]        lookup_mac
);

    arp_rc_pkg::q_status_t cq_status;
    arp_rc_pkg::cmd_t      cmd_in;
    arp_rc_pkg::cmd_t      cmd_out;
    arp_rc_pkg::res_t      res;
    logic                  cmd_push;
    logic                  cmd_pop;

    arp_rc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .action      (action),
        .long_enough (long_enough),
        .hw_type     (hw_type),
        .proto_type  (proto_type),
        .hw_len      (hw_len),
        .proto_len   (proto_len),
        .opcode      (opcode),
        .sender_mac  (sender_mac),
        .sender_ip   (sender_ip),
        .target_ip   (target_ip),
        .query_ip    (query_ip),
        .cq_status   (cq_status),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    arp_rc_cmdq u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .status  (cq_status)
    );

    arp_rc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cq_status (cq_status),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign full             = cq_status.full;
    assign frame_kind       = res.kind;
    assign frame_dest_mac   = res.dest_mac;
    assign frame_target_mac = res.target_mac;
    assign frame_target_ip  = res.target_ip;
    assign learned          = res.learned;
    assign lookup_hit       = res.hit;
    assign lookup_mac       = res.lookup_mac;

endmodule

// File: tb/sv/arp_responder_and_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder and cache result checker
// Watches the register port and both queue sides of the block. It keeps its
// own copy of the station registers and of the address cache, predicts the
// frame descriptor for every item transfer, and compares each result transfer
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module arp_responder_and_cache_checker
    import arp_rc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    input  logic                  full,
    input  logic                  action,
    input  logic                  long_enough,
    input  logic [15:0]           hw_type,
    input  logic [15:0]           proto_type,
    input  logic [7:0]            hw_len,
    input  logic [7:0]            proto_len,
    input  logic [15:0]           opcode,
    input  logic [MAC_W-1:0]      sender_mac,
    input  logic [IP_W-1:0]       sender_ip,
    input  logic [IP_W-1:0]       target_ip,
    input  logic [IP_W-1:0]       query_ip,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [1:0]            frame_kind,
    input  logic [MAC_W-1:0]      frame_dest_mac,
    input  logic [MAC_W-1:0]      frame_target_mac,
    input  logic [IP_W-1:0]       frame_target_ip,
    input  logic                  learned,
    input  logic                  lookup_hit,
    input  logic [MAC_W-1:0]      lookup_mac,
    output int                    mismatches,
    output int                    pending,
    output int                    replies_seen,
    output int                    hits_seen,
    output int                    learned_seen
);

    res_t              frames_due [$];
    res_t              want;
    logic [MAC_W-1:0]  station_mac;
    logic [IP_W-1:0]   station_ip;
    logic              entry_valid [CACHE_SLOTS];
    logic [IP_W-1:0]   entry_ip    [CACHE_SLOTS];
    logic [MAC_W-1:0]  entry_mac   [CACHE_SLOTS];
    logic [SLOT_W-1:0] replace_ptr;

    function automatic int cache_find(logic [IP_W-1:0] ip);
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (entry_valid[i] && entry_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    function automatic logic cache_learn(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        int slot;
        if (cache_find(ip) >= 0)
            return 1'b0;
        slot = -1;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--)
        begin
            if (!entry_valid[i])
                slot = i;
        end
        if (slot < 0)
        begin
            slot = int'(replace_ptr);
            replace_ptr = replace_ptr + 1'b1;
        end
        entry_valid[slot] = 1'b1;
        entry_ip[slot]    = ip;
        entry_mac[slot]   = mac;
        return 1'b1;
    endfunction

    function automatic res_t arp_outcome();
        res_t r;
        int   slot;
        r = '0;
        if (action)
        begin
            slot = cache_find(query_ip);
            if (slot >= 0)
            begin
                r.hit        = 1'b1;
                r.lookup_mac = entry_mac[slot];
            end
            else
            begin
                r.kind      = KIND_REQUEST;
                r.dest_mac  = BCAST_MAC;
                r.target_ip = query_ip;
            end
        end
        else if (long_enough && hw_type == HW_TYPE_ETH && proto_type == PROTO_IPV4 &&
                 hw_len == HW_LEN_ETH && proto_len == PROTO_LEN_IPV4 &&
                 target_ip == station_ip)
        begin
            if (opcode == OP_REQUEST)
            begin
                r.kind       = KIND_REPLY;
                r.dest_mac   = sender_mac;
                r.target_mac = sender_mac;
                r.target_ip  = sender_ip;
            end
            else if (opcode == OP_REPLY)
            begin
                r.learned = cache_learn(sender_ip, sender_mac);
            end
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, field, expected, actual);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches   = 0;
        replies_seen = 0;
        hits_seen    = 0;
        learned_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_due.delete();
            station_mac = '0;
            station_ip  = '0;
            replace_ptr = '0;
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                entry_valid[i] = 1'b0;
                entry_ip[i]    = '0;
                entry_mac[i]   = '0;
            end
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_OWN_MAC)
                    station_mac = cfg_wdata[MAC_W-1:0];
                else if (cfg_index == CFG_OWN_IP)
                    station_ip = cfg_wdata[IP_W-1:0];
            end
            if (pop && !empty)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t ns: result transfer with nothing expected, kind %0d",
                             $time, frame_kind);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("frame_kind", want.kind, frame_kind);
                    check_field("frame_dest_mac", want.dest_mac, frame_dest_mac);
                    check_field("frame_target_mac", want.target_mac, frame_target_mac);
                    check_field("frame_target_ip", want.target_ip, frame_target_ip);
                    check_field("learned", want.learned, learned);
                    check_field("lookup_hit", want.hit, lookup_hit);
                    check_field("lookup_mac", want.lookup_mac, lookup_mac);
                    if (want.kind == KIND_REPLY)
                        replies_seen++;
                    if (want.hit)
                        hits_seen++;
                    if (want.learned)
                        learned_seen++;
                end
            end
            if (push && !full)
                frames_due.push_back(arp_outcome());
            pending <= frames_due.size();
        end
    end

endmodule

// File: tb/sv/arp_responder_and_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder and cache testbench
// Drives ARP messages and cache lookups into the block under a series of
// station address settings, with random gaps on both sides, one long result
// hold-off and one stretch at full rate. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module arp_responder_and_cache_tb;
    import arp_rc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int POOL_SIZE       = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum int {
        FLAW_SHORT,
        FLAW_HW_TYPE,
        FLAW_PROTO_TYPE,
        FLAW_HW_LEN,
        FLAW_PROTO_LEN,
        FLAW_TARGET,
        FLAW_OPCODE,
        FLAW_COUNT
    } flaw_t;

    typedef struct packed {
        logic             action;
        logic             long_enough;
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
        logic [IP_W-1:0]  query_ip;
    } arp_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  push;
    logic                  full;
    logic                  action;
    logic                  long_enough;
    logic [15:0]           hw_type;
    logic [15:0]           proto_type;
    logic [7:0]            hw_len;
    logic [7:0]            proto_len;
    logic [15:0]           opcode;
    logic [MAC_W-1:0]      sender_mac;
    logic [IP_W-1:0]       sender_ip;
    logic [IP_W-1:0]       target_ip;
    logic [IP_W-1:0]       query_ip;
    logic                  empty;
    logic                  pop;
    logic [1:0]            frame_kind;
    logic [MAC_W-1:0]      frame_dest_mac;
    logic [MAC_W-1:0]      frame_target_mac;
    logic [IP_W-1:0]       frame_target_ip;
    logic                  learned;
    logic                  lookup_hit;
    logic [MAC_W-1:0]      lookup_mac;

    int mismatches;
    int pending;
    int replies_seen;
    int hits_seen;
    int learned_seen;

    logic            steady;
    logic            hold_req;
    logic [IP_W-1:0] known_ips [POOL_SIZE];
    int              items_sent;
    int              settings_used;

    arp_responder_and_cache u_top (.*);

    arp_responder_and_cache_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi[15:0], lo};
    endfunction

    function automatic arp_item_t random_fields();
        arp_item_t   it;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        it.action      = a[0];
        it.long_enough = a[1];
        it.hw_len      = a[15:8];
        it.proto_len   = a[23:16];
        it.hw_type     = b[15:0];
        it.proto_type  = b[31:16];
        a = $urandom;
        it.opcode      = a[15:0];
        it.sender_mac  = rand_mac();
        it.sender_ip   = $urandom;
        it.target_ip   = $urandom;
        it.query_ip    = $urandom;
        return it;
    endfunction

    function automatic arp_item_t arp_message(logic [15:0] op, logic [MAC_W-1:0] mac,
                                              logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
        arp_item_t it;
        it = random_fields();
        it.action      = 1'b0;
        it.long_enough = 1'b1;
        it.hw_type     = HW_TYPE_ETH;
        it.proto_type  = PROTO_IPV4;
        it.hw_len      = HW_LEN_ETH;
        it.proto_len   = PROTO_LEN_IPV4;
        it.opcode      = op;
        it.sender_mac  = mac;
        it.sender_ip   = sip;
        it.target_ip   = tip;
        return it;
    endfunction

    function automatic arp_item_t lookup_query(logic [IP_W-1:0] qip);
        arp_item_t it;
        it = random_fields();
        it.action   = 1'b1;
        it.query_ip = qip;
        return it;
    endfunction

    function automatic arp_item_t broken_message(flaw_t flaw, logic [IP_W-1:0] self_ip);
        arp_item_t   it;
        logic [31:0] nz;
        nz = $urandom;
        nz[0] = 1'b1;
        it = arp_message(nz[1] ? OP_REQUEST : OP_REPLY, rand_mac(), $urandom, self_ip);
        case (flaw)
            FLAW_SHORT:      it.long_enough = 1'b0;
            FLAW_HW_TYPE:    it.hw_type     = it.hw_type ^ nz[15:0];
            FLAW_PROTO_TYPE: it.proto_type  = it.proto_type ^ nz[15:0];
            FLAW_HW_LEN:     it.hw_len      = it.hw_len ^ nz[7:0];
            FLAW_PROTO_LEN:  it.proto_len   = it.proto_len ^ nz[7:0];
            FLAW_TARGET:     it.target_ip   = it.target_ip ^ nz;
            default:         it.opcode      = it.opcode ^ {1'b1, nz[14:0]};
        endcase
        return it;
    endfunction

    // Most traffic is well formed and reuses a small address pool, so the
    // cache fills, wraps its refill pointer and serves lookup hits.
    function automatic arp_item_t random_item(logic [IP_W-1:0] self_ip);
        arp_item_t   it;
        logic [31:0] r32;
        int          pick;
        pick = $urandom_range(99);
        r32  = $urandom;
        if (pick < 25)
            it = arp_message(OP_REQUEST, rand_mac(), r32, self_ip);
        else if (pick < 50)
            it = arp_message(OP_REPLY, rand_mac(), known_ips[$urandom_range(POOL_SIZE - 1)],
                             self_ip);
        else if (pick < 80)
            it = lookup_query(($urandom_range(9) < 7) ?
                              known_ips[$urandom_range(POOL_SIZE - 1)] : r32);
        else if (pick < 90)
            it = broken_message(flaw_t'($urandom_range(FLAW_COUNT - 1)), self_ip);
        else
        begin
            it = random_fields();
            if (r32[0])
                it.target_ip = self_ip;
        end
        return it;
    endfunction

    task automatic present_item(arp_item_t it);
        action      <= it.action;
        long_enough <= it.long_enough;
        hw_type     <= it.hw_type;
        proto_type  <= it.proto_type;
        hw_len      <= it.hw_len;
        proto_len   <= it.proto_len;
        opcode      <= it.opcode;
        sender_mac  <= it.sender_mac;
        sender_ip   <= it.sender_ip;
        target_ip   <= it.target_ip;
        query_ip    <= it.query_ip;
    endtask

    task automatic send_item(arp_item_t it);
        present_item(it);
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        items_sent++;
    endtask

    task automatic tx_gap();
        int n;
        n = 0;
        if (!steady)
        begin
            while ($urandom_range(99) < 37)
                n++;
        end
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_regs(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                              logic [CFG_IDX_W-1:0] spare);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_MAC;
        cfg_wdata <= mac;
        @(posedge clk);
        cfg_index <= CFG_OWN_IP;
        cfg_wdata <= {junk[15:0], ip};
        @(posedge clk);
        cfg_index <= spare;
        cfg_wdata <= rand_mac();
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_spaced(arp_item_t it);
        send_item(it);
        tx_gap();
    endtask

    initial
    begin : stimulus
        logic [IP_W-1:0]  self_ip;
        logic [MAC_W-1:0] self_mac;
        logic [IP_W-1:0]  addr_a;
        logic [MAC_W-1:0] mac_a;
        items_sent    = 0;
        settings_used = 1;
        self_ip       = '0;
        self_mac      = '0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_OWN_MAC;
        cfg_wdata <= '0;
        steady    <= 1'b0;
        hold_req  <= 1'b0;
        present_item('0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset values of the station registers.
        addr_a = $urandom;
        mac_a  = rand_mac();
        send_spaced(lookup_query('0));
        send_spaced(lookup_query('1));
        send_spaced(arp_message(OP_REQUEST, '1, '1, self_ip));
        send_spaced(arp_message(OP_REQUEST, '0, '0, self_ip));
        for (int k = 0; k < FLAW_COUNT; k++)
            send_spaced(broken_message(flaw_t'(k), self_ip));
        send_spaced(arp_message(16'h0000, rand_mac(), $urandom, self_ip));
        send_spaced(arp_message(16'hFFFF, rand_mac(), $urandom, self_ip));
        send_spaced(arp_message(OP_REPLY, mac_a, addr_a, self_ip));
        send_spaced(arp_message(OP_REPLY, ~mac_a, addr_a, self_ip));
        send_spaced(lookup_query(addr_a));
        send_spaced(arp_message(OP_REPLY, '1, '0, self_ip));
        send_spaced(arp_message(OP_REPLY, '0, '1, self_ip));
        send_spaced(lookup_query('0));
        send_spaced(lookup_query('1));
        send_spaced(lookup_query(~addr_a));

        known_ips[0] = '0;
        known_ips[1] = '1;
        known_ips[2] = addr_a;
        for (int i = 3; i < POOL_SIZE; i++)
            known_ips[i] = $urandom;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drain();
            case (phase)
                0:
                begin
                    self_mac = '1;
                    self_ip  = '1;
                end
                2:
                begin
                    self_mac = '0;
                    self_ip  = $urandom;
                end
                3:
                begin
                    self_mac = 48'hAAAA_AAAA_AAAA;
                    self_ip  = 32'h5555_5555;
                end
                4:
                begin
                    self_mac = rand_mac();
                    self_ip  = '0;
                end
                default:
                begin
                    self_mac = rand_mac();
                    self_ip  = $urandom;
                end
            endcase
            write_regs(self_mac, self_ip, phase[0] ? CFG_SPARE_HI : CFG_SPARE_LO);
            if (phase == 1)
                hold_req <= 1'b1;
            if (phase == 3)
                steady <= 1'b1;
            if (phase == 4)
                steady <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_spaced(random_item(self_ip));
        end

        wait_drain();
        repeat (16) @(posedge clk);
        $display("Covered %0d item transfers over %0d station address settings.",
                 items_sent, settings_used);
        $display("Checked %0d ARP replies, %0d lookup hits and %0d cache insertions.",
                 replies_seen, hits_seen, learned_seen);
        if (mismatches == 0)
            $display("arp_responder_and_cache verification clean");
        else
            $display("arp_responder_and_cache verification failed");
        $finish;
    end

    // Result side: random pops, a full-rate stretch, and one long hold-off
    // so that the block backs up and raises full.
    initial
    begin : result_drain
        bit held;
        held = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                pop <= steady || ($urandom_range(99) >= 37);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout after %0d cycles without a transfer.", WATCHDOG_LIMIT);
        $display("arp_responder_and_cache verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/arp_rc_pkg.sv
rtl/arp_rc_front.sv
rtl/arp_rc_cmdq.sv
rtl/arp_rc_back.sv
rtl/arp_responder_and_cache.sv
tb/sv/arp_responder_and_cache_checker.sv
tb/sv/arp_responder_and_cache_tb.sv
